@@ sv/gtfp_pkg.sv @@
// Shared types, constants and decode functions of the gimbal telemetry frame parser.
`default_nettype none

package gtfp_pkg;

    // Header bytes that open every frame.
    localparam logic [7:0] HDR0 = 8'hEE;
    localparam logic [7:0] HDR1 = 8'h01;
    localparam logic [7:0] HDR2 = 8'h1D;

    // Frame bytes 3 to 28 follow the header; the last of them is the checksum.
    localparam int PAYLOAD_LEN = 26;
    localparam int POS_W       = 5;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_LEN - 1);

    // Tracking codes.
    localparam logic [1:0] TRACK_OFF     = 2'd0;
    localparam logic [1:0] TRACK_ON      = 2'd1;
    localparam logic [1:0] TRACK_UNKNOWN = 2'd2;

    // Gimbal mode codes.
    localparam logic [1:0] MODE_FOLLOW  = 2'd0;
    localparam logic [1:0] MODE_LOCK    = 2'd1;
    localparam logic [1:0] MODE_DOWN    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // Header hunt phases of the front end.
    typedef enum logic [1:0] {
        HUNT_SYNC0,
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_COLLECT
    } hunt_t;

    // One classified payload byte travelling from the front end to the back end.
    typedef struct packed {
        logic             last;
        logic             sum_ok;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } cmd_t;

    // One decoded telemetry frame.
    typedef struct packed {
        logic        [15:0] distance_dm;
        logic signed [15:0] roll_tenths;
        logic signed [15:0] pitch_tenths;
        logic signed [15:0] yaw_tenths;
        logic        [7:0]  zoom_level;
        logic        [1:0]  tracking_code;
        logic signed [31:0] target_lat;
        logic signed [31:0] target_lon;
        logic signed [15:0] target_alt_dm;
        logic        [31:0] focal_word;
        logic        [1:0]  mode_code;
        logic               checksum_ok;
    } frame_t;

    // Maps the raw tracking byte to its code.
    function automatic logic [1:0] decode_tracking(input logic [7:0] raw);
        logic [1:0] code;
        case (raw)
            8'h00:   code = TRACK_OFF;
            8'h01:   code = TRACK_ON;
            default: code = TRACK_UNKNOWN;
        endcase
        return code;
    endfunction

    // Maps the raw mode byte to its code.
    function automatic logic [1:0] decode_mode(input logic [7:0] raw);
        logic [1:0] code;
        case (raw)
            8'h00:   code = MODE_FOLLOW;
            8'h01:   code = MODE_LOCK;
            8'h02:   code = MODE_DOWN;
            default: code = MODE_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/gtfp_if.sv @@
// Handshake interfaces for received bytes and decoded telemetry frames.
`default_nettype none

interface gtfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gtfp_frame_if;
    logic               valid;
    logic               ready;
    gtfp_pkg::frame_t   frame;

    modport source (output valid, output frame, input ready);
    modport sink (input valid, input frame, output ready);
endinterface

`default_nettype wire

@@ sv/gimbal_telemetry_frame_parser_unit.sv @@
// Top level of the gimbal telemetry frame parser.
// The parser takes one received byte per clock cycle while the queue has room, hunts for the
// EE 01 1D header and, after the 26 bytes that follow it, delivers one decoded frame with its
// checksum flag; a byte that breaks the header restarts the hunt and is not itself treated as a
// new start. The front end classifies every byte in the cycle it arrives, a queue of
// QUEUE_DEPTH entries carries payload bytes to the back end, and the back end stores them and
// decodes the frame into an output register. A frame's valid flag is registered when the back
// end takes its checksum byte from the queue. Input bytes keep flowing while a frame waits to be
// taken, until the queue fills behind the next closing byte.
`default_nettype none

module gimbal_telemetry_frame_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    gtfp_byte_if.sink       rx,
    gtfp_frame_if.source    telemetry
);

    logic                   front_valid;
    gtfp_pkg::cmd_t         front_cmd;
    logic                   front_ready;
    logic                   back_valid;
    gtfp_pkg::cmd_t         back_cmd;
    logic                   back_ready;

    // Header hunt and classification.
    gtfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_data   (rx.rx_byte),
        .in_ready  (rx.ready),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    // Decoupling queue.
    gtfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .in_ready  (front_ready),
        .out_valid (back_valid),
        .out_cmd   (back_cmd),
        .out_ready (back_ready)
    );

    // Payload store and frame decode.
    gtfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_ready (back_ready),
        .out_valid (telemetry.valid),
        .out_frame (telemetry.frame),
        .out_ready (telemetry.ready)
    );

endmodule

`default_nettype wire

@@ sv/gtfp_front.sv @@
// Front end: header hunt, payload position tracking and checksum accumulation.
`default_nettype none

module gtfp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_data,
    output logic                       in_ready,
    output logic                       cmd_valid,
    output gtfp_pkg::cmd_t             cmd,
    input  wire logic                  cmd_ready
);

    gtfp_pkg::hunt_t                   state_reg, state_next;
    logic [gtfp_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [7:0]                        sum_reg, sum_next;
    logic                              accept;

    // A byte is taken whenever the queue has room for what it may produce.
    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;

    // Classified byte handed to the queue.
    assign cmd.last   = (pos_reg == gtfp_pkg::LAST_POS);
    assign cmd.sum_ok = (sum_reg == in_data);
    assign cmd.pos    = pos_reg;
    assign cmd.data   = in_data;

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtfp_pkg::HUNT_SYNC0;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Next state: a broken header returns to the first phase without rechecking the byte.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        cmd_valid  = 1'b0;
        if (accept)
        begin
            case (state_reg)
                gtfp_pkg::HUNT_SYNC0:
                begin
                    pos_next = '0;
                    if (in_data == gtfp_pkg::HDR0)
                    begin
                        sum_next   = in_data;
                        state_next = gtfp_pkg::HUNT_SYNC1;
                    end
                    else
                    begin
                        sum_next = '0;
                    end
                end
                gtfp_pkg::HUNT_SYNC1:
                begin
                    if (in_data == gtfp_pkg::HDR1)
                    begin
                        sum_next   = sum_reg + in_data;
                        state_next = gtfp_pkg::HUNT_SYNC2;
                    end
                    else
                    begin
                        state_next = gtfp_pkg::HUNT_SYNC0;
                    end
                end
                gtfp_pkg::HUNT_SYNC2:
                begin
                    if (in_data == gtfp_pkg::HDR2)
                    begin
                        sum_next   = sum_reg + in_data;
                        pos_next   = '0;
                        state_next = gtfp_pkg::HUNT_COLLECT;
                    end
                    else
                    begin
                        state_next = gtfp_pkg::HUNT_SYNC0;
                    end
                end
                gtfp_pkg::HUNT_COLLECT:
                begin
                    cmd_valid = 1'b1;
                    if (pos_reg == gtfp_pkg::LAST_POS)
                    begin
                        pos_next   = '0;
                        sum_next   = '0;
                        state_next = gtfp_pkg::HUNT_SYNC0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                        sum_next = sum_reg + in_data;
                    end
                end
                default:
                begin
                    state_next = gtfp_pkg::HUNT_SYNC0;
                end
            endcase
        end
    end

    // Outside collection the payload position stays at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gtfp_pkg::HUNT_COLLECT) |-> (pos_reg == '0))
        else $error("payload position moved outside collection");

    // A closing transfer only leaves the front end at the checksum byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.last) |-> (state_reg == gtfp_pkg::HUNT_COLLECT
                                     && pos_reg == gtfp_pkg::LAST_POS))
        else $error("frame closed at the wrong position");

    // After the checksum byte the hunt restarts with a cleared sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg == gtfp_pkg::HUNT_COLLECT && pos_reg == gtfp_pkg::LAST_POS)
        |=> (state_reg == gtfp_pkg::HUNT_SYNC0 && sum_reg == '0))
        else $error("hunt did not restart after a frame");

endmodule

`default_nettype wire

@@ sv/gtfp_queue.sv @@
// Short queue of classified payload bytes between the front and back ends.
`default_nettype none

module gtfp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire gtfp_pkg::cmd_t in_cmd,
    output logic                in_ready,
    output logic                out_valid,
    output gtfp_pkg::cmd_t      out_cmd,
    input  wire logic           out_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gtfp_pkg::cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/gtfp_back.sv @@
// Back end: payload byte store, field decoding and the output frame register.
`default_nettype none

module gtfp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire gtfp_pkg::cmd_t cmd,
    output logic                cmd_ready,
    output logic                out_valid,
    output gtfp_pkg::frame_t    out_frame,
    input  wire logic           out_ready
);

    // Frame bytes 3 to 27; the checksum byte is compared in the front end.
    logic [7:0]                 store_reg [gtfp_pkg::PAYLOAD_LEN - 1];
    gtfp_pkg::frame_t           frame_reg, frame_next;
    logic                       valid_reg, valid_next;
    logic                       pop, finish;

    // A closing transfer waits only while an untaken frame holds the output register.
    assign cmd_ready = !cmd.last || !valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign finish    = pop && cmd.last;
    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

    // Assemble the decoded frame from the stored bytes.
    always_comb
    begin
        frame_next.distance_dm   = {store_reg[1], store_reg[0]};
        frame_next.roll_tenths   = {store_reg[3], store_reg[2]};
        frame_next.pitch_tenths  = {store_reg[5], store_reg[4]};
        frame_next.yaw_tenths    = {store_reg[7], store_reg[6]};
        frame_next.zoom_level    = store_reg[8];
        frame_next.tracking_code = gtfp_pkg::decode_tracking(store_reg[9]);
        frame_next.target_lat    = {store_reg[13], store_reg[12], store_reg[11], store_reg[10]};
        frame_next.target_lon    = {store_reg[17], store_reg[16], store_reg[15], store_reg[14]};
        frame_next.target_alt_dm = {store_reg[19], store_reg[18]};
        frame_next.focal_word    = {store_reg[20], store_reg[21], store_reg[22], store_reg[23]};
        frame_next.mode_code     = gtfp_pkg::decode_mode(store_reg[24]);
        frame_next.checksum_ok   = cmd.sum_ok;
    end

    // Output valid flag.
    always_comb
    begin
        valid_next = valid_reg;
        if (finish)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload store and output frame need no reset.
    always_ff @(posedge clk)
    begin
        if (pop && !cmd.last)
        begin
            store_reg[cmd.pos] <= cmd.data;
        end
        if (finish)
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the gimbal telemetry frame parser unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    // Run length, watchdog and settling time after the last transfer.
    localparam int RANDOM_BYTES = 1140;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_BOUND  = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam int BODY_LEN     = gtfp_pkg::PAYLOAD_LEN - 1;

    logic clk;
    logic rst_n;

    gtfp_byte_if  rx_if ();
    gtfp_frame_if tlm_if ();

    gimbal_telemetry_frame_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if.sink),
        .telemetry (tlm_if.source)
    );

    // Shadow of the parser state, advanced on every accepted byte.
    gtfp_pkg::hunt_t shadow_phase;
    logic [4:0]      shadow_pos;
    logic [7:0]      shadow_sum;
    logic [7:0]      shadow_store [gtfp_pkg::PAYLOAD_LEN];

    // Decoded frames still owed by the block, oldest first.
    gtfp_pkg::frame_t frames_due [$];

    // Frame bytes 3 to 27 of the next frame to be sent.
    logic [7:0] frame_body [BODY_LEN];

    // Idling controls for the byte source and the frame sink.
    bit source_gaps_on;
    bit sink_stalls_on;

    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned frames_checked;
    int unsigned frames_sent;
    int unsigned bad_sum_sent;
    int unsigned broken_headers;
    int unsigned mismatch_count;
    int unsigned error_count;

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Advances the shadow state by one accepted byte and queues any frame it closes.
    function automatic void decode_rx_byte(input logic [7:0] b);
        gtfp_pkg::frame_t f;
        logic [7:0] t;
        logic [7:0] m;
        case (shadow_phase)
            gtfp_pkg::HUNT_SYNC0:
            begin
                shadow_sum = 8'h00;
                shadow_pos = '0;
                if (b == gtfp_pkg::HDR0)
                begin
                    shadow_sum   = b;
                    shadow_phase = gtfp_pkg::HUNT_SYNC1;
                end
            end
            gtfp_pkg::HUNT_SYNC1:
            begin
                if (b == gtfp_pkg::HDR1)
                begin
                    shadow_sum   = shadow_sum + b;
                    shadow_phase = gtfp_pkg::HUNT_SYNC2;
                end
                else
                    shadow_phase = gtfp_pkg::HUNT_SYNC0;
            end
            gtfp_pkg::HUNT_SYNC2:
            begin
                if (b == gtfp_pkg::HDR2)
                begin
                    shadow_sum   = shadow_sum + b;
                    shadow_phase = gtfp_pkg::HUNT_COLLECT;
                    shadow_pos   = '0;
                end
                else
                    shadow_phase = gtfp_pkg::HUNT_SYNC0;
            end
            default:
            begin
                if (shadow_pos > gtfp_pkg::LAST_POS)
                begin
                    shadow_pos   = '0;
                    shadow_sum   = 8'h00;
                    shadow_phase = gtfp_pkg::HUNT_SYNC0;
                end
                else if (shadow_pos < gtfp_pkg::LAST_POS)
                begin
                    // Frame bytes 3 to 27 enter the running sum.
                    shadow_store[shadow_pos] = b;
                    shadow_sum = shadow_sum + b;
                    shadow_pos = shadow_pos + 1'b1;
                end
                else
                begin
                    // The checksum byte closes the frame.
                    shadow_store[shadow_pos] = b;
                    f.distance_dm   = {shadow_store[1], shadow_store[0]};
                    f.roll_tenths   = {shadow_store[3], shadow_store[2]};
                    f.pitch_tenths  = {shadow_store[5], shadow_store[4]};
                    f.yaw_tenths    = {shadow_store[7], shadow_store[6]};
                    f.zoom_level    = shadow_store[8];
                    t = shadow_store[9];
                    if (t == 8'h00)
                        f.tracking_code = gtfp_pkg::TRACK_OFF;
                    else if (t == 8'h01)
                        f.tracking_code = gtfp_pkg::TRACK_ON;
                    else
                        f.tracking_code = gtfp_pkg::TRACK_UNKNOWN;
                    f.target_lat    = {shadow_store[13], shadow_store[12],
                                       shadow_store[11], shadow_store[10]};
                    f.target_lon    = {shadow_store[17], shadow_store[16],
                                       shadow_store[15], shadow_store[14]};
                    f.target_alt_dm = {shadow_store[19], shadow_store[18]};
                    f.focal_word    = {shadow_store[20], shadow_store[21],
                                       shadow_store[22], shadow_store[23]};
                    m = shadow_store[24];
                    if (m == 8'h00)
                        f.mode_code = gtfp_pkg::MODE_FOLLOW;
                    else if (m == 8'h01)
                        f.mode_code = gtfp_pkg::MODE_LOCK;
                    else if (m == 8'h02)
                        f.mode_code = gtfp_pkg::MODE_DOWN;
                    else
                        f.mode_code = gtfp_pkg::MODE_UNKNOWN;
                    f.checksum_ok = (shadow_sum == shadow_store[25]);
                    frames_due.insert(frames_due.size(), f);
                    shadow_phase = gtfp_pkg::HUNT_SYNC0;
                    shadow_pos   = '0;
                    shadow_sum   = 8'h00;
                end
            end
        endcase
    endfunction

    // Sends one byte, with an optional gap before it, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = source_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        decode_rx_byte(b);
        bytes_sent++;
    endtask

    // Sends header, frame_body and checksum; a non-zero skew spoils the checksum.
    task automatic send_frame(input logic [7:0] skew);
        logic [7:0] sum;
        sum = gtfp_pkg::HDR0 + gtfp_pkg::HDR1 + gtfp_pkg::HDR2;
        send_byte(gtfp_pkg::HDR0);
        send_byte(gtfp_pkg::HDR1);
        send_byte(gtfp_pkg::HDR2);
        for (int i = 0; i < BODY_LEN; i++)
        begin
            send_byte(frame_body[i]);
            sum = sum + frame_body[i];
        end
        send_byte(sum + skew);
        frames_sent++;
        if (skew != 8'h00)
            bad_sum_sent++;
    endtask

    function automatic void fill_body_random();
        for (int i = 0; i < BODY_LEN; i++)
            frame_body[i] = 8'($urandom_range(0, 255));
    endfunction

    function automatic void fill_body_const(input logic [7:0] v);
        for (int i = 0; i < BODY_LEN; i++)
            frame_body[i] = v;
    endfunction

    // Holds the source until every owed frame has arrived, or the drain bound is reached, and the block has settled.
    task automatic wait_drained();
        int waited;
        rx_if.valid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < DRAIN_BOUND)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Frame sink: random stalls on the ready line when enabled.
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        tlm_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                tlm_if.ready <= 1'b0;
            end
            else if (sink_stalls_on && $urandom_range(0, 99) < 30)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    stall_left = $urandom_range(0, 2);
                else if (r < 95)
                    stall_left = $urandom_range(3, 10);
                else
                    stall_left = $urandom_range(20, 60);
                tlm_if.ready <= 1'b0;
            end
            else
                tlm_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("tb_top: mismatch on %s in frame %0d: expected %h, got %h",
                         name, frames_checked, want, got);
        end
    endtask

    // Compares each frame transfer with the oldest owed frame.
    always @(posedge clk)
    begin
        gtfp_pkg::frame_t want;
        gtfp_pkg::frame_t got;
        if (rst_n && tlm_if.valid && tlm_if.ready)
        begin
            got = tlm_if.frame;
            if (frames_due.size() == 0)
            begin
                error_count++;
                $display("tb_top: frame delivered with none owed, focal %h", got.focal_word);
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("distance_dm", 32'(want.distance_dm), 32'(got.distance_dm));
                check_field("roll_tenths", 32'(want.roll_tenths), 32'(got.roll_tenths));
                check_field("pitch_tenths", 32'(want.pitch_tenths), 32'(got.pitch_tenths));
                check_field("yaw_tenths", 32'(want.yaw_tenths), 32'(got.yaw_tenths));
                check_field("zoom_level", 32'(want.zoom_level), 32'(got.zoom_level));
                check_field("tracking_code", 32'(want.tracking_code),
                            32'(got.tracking_code));
                check_field("target_lat", want.target_lat, got.target_lat);
                check_field("target_lon", want.target_lon, got.target_lon);
                check_field("target_alt_dm", 32'(want.target_alt_dm),
                            32'(got.target_alt_dm));
                check_field("focal_word", want.focal_word, got.focal_word);
                check_field("mode_code", 32'(want.mode_code), 32'(got.mode_code));
                check_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
                frames_checked++;
            end
        end
    end

    // All-zero and all-ones payloads, then boundary values in the distance, angle, zoom, position and altitude fields.
    task automatic test_field_extremes();
        fill_body_const(8'h00);
        send_frame(8'h00);
        fill_body_const(8'hFF);
        send_frame(8'h00);
        fill_body_const(8'h00);
        frame_body[0]  = 8'hFF; frame_body[1]  = 8'hFF;
        frame_body[2]  = 8'h00; frame_body[3]  = 8'h80;
        frame_body[4]  = 8'hFF; frame_body[5]  = 8'h7F;
        frame_body[6]  = 8'h01; frame_body[7]  = 8'h80;
        frame_body[8]  = 8'hFF;
        frame_body[10] = 8'h00; frame_body[11] = 8'h00;
        frame_body[12] = 8'h00; frame_body[13] = 8'h80;
        frame_body[14] = 8'hFF; frame_body[15] = 8'hFF;
        frame_body[16] = 8'hFF; frame_body[17] = 8'h7F;
        frame_body[18] = 8'hFF; frame_body[19] = 8'hFF;
        frame_body[20] = 8'h12; frame_body[21] = 8'h34;
        frame_body[22] = 8'h56; frame_body[23] = 8'h78;
        send_frame(8'h00);
    endtask

    // Each tracking code and the lock, down and unknown mode codes, including unknown raw values.
    task automatic test_status_codes();
        fill_body_random();
        frame_body[9] = 8'h01; frame_body[24] = 8'h01;
        send_frame(8'h00);
        fill_body_random();
        frame_body[9] = 8'h02; frame_body[24] = 8'h02;
        send_frame(8'h00);
        fill_body_random();
        frame_body[9] = 8'h00; frame_body[24] = 8'h03;
        send_frame(8'h00);
    endtask

    // A spoilt checksum still yields a frame, flagged as bad.
    task automatic test_bad_checksum();
        fill_body_random();
        send_frame(8'h01);
        fill_body_random();
        send_frame(8'hFF);
    endtask

    // Header bytes inside the payload are plain data.
    task automatic test_header_in_payload();
        for (int i = 0; i < BODY_LEN; i++)
            frame_body[i] = (i % 3 == 0) ? gtfp_pkg::HDR0 :
                            (i % 3 == 1) ? gtfp_pkg::HDR1 : gtfp_pkg::HDR2;
        send_frame(8'h00);
    endtask

    // Broken headers: the breaking byte is never taken as a new start.
    task automatic test_broken_header();
        send_byte(gtfp_pkg::HDR0);
        send_byte(8'h02);
        send_byte(gtfp_pkg::HDR0);
        send_byte(gtfp_pkg::HDR0);
        send_byte(gtfp_pkg::HDR1);
        send_byte(gtfp_pkg::HDR2);
        for (int i = 0; i < gtfp_pkg::PAYLOAD_LEN; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(gtfp_pkg::HDR0);
        send_byte(gtfp_pkg::HDR1);
        send_byte(gtfp_pkg::HDR0);
        send_byte(gtfp_pkg::HDR1);
        send_byte(gtfp_pkg::HDR2);
        broken_headers += 3;
        fill_body_random();
        send_frame(8'h00);
    endtask

    // Frames back to back at full rate on both sides, then the same under stalls.
    task automatic test_back_to_back();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (3)
        begin
            fill_body_random();
            send_frame(8'h00);
        end
        sink_stalls_on = 1'b1;
        repeat (3)
        begin
            fill_body_random();
            send_frame(8'h00);
        end
    endtask

    // The source pauses until every owed frame has arrived or the drain bound is reached, then resumes.
    task automatic test_drain_pause();
        fill_body_random();
        send_frame(8'h00);
        wait_drained();
        fill_body_random();
        send_frame(8'h00);
    endtask

    // Mostly well-formed frames with random content, mixed with noise and broken headers.
    task automatic test_random_traffic();
        int unsigned stop_at;
        int r;
        int n;
        logic [7:0] b;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            // Change the idling pattern every now and then.
            if ($urandom_range(0, 7) == 0)
            begin
                source_gaps_on = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                fill_body_random();
                n = $urandom_range(0, 4);
                frame_body[9]  = (n < 3) ? 8'(n) : 8'($urandom_range(0, 255));
                n = $urandom_range(0, 4);
                frame_body[24] = (n < 4) ? 8'(n) : 8'($urandom_range(0, 255));
                send_frame(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
            end
            else if (r < 80)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 92)
            begin
                // Header broken after one or two good bytes.
                send_byte(gtfp_pkg::HDR0);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(gtfp_pkg::HDR1);
                    do
                        b = ($urandom_range(0, 2) == 0) ? gtfp_pkg::HDR0
                                                        : 8'($urandom_range(0, 255));
                    while (b == gtfp_pkg::HDR2);
                end
                else
                begin
                    do
                        b = ($urandom_range(0, 2) == 0) ? gtfp_pkg::HDR0
                                                        : 8'($urandom_range(0, 255));
                    while (b == gtfp_pkg::HDR1);
                end
                send_byte(b);
                broken_headers++;
            end
            else
            begin
                // Truncated frame: the next header lands inside its payload.
                send_byte(gtfp_pkg::HDR0);
                send_byte(gtfp_pkg::HDR1);
                send_byte(gtfp_pkg::HDR2);
                n = $urandom_range(0, BODY_LEN - 1);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        bytes_sent     = 0;
        frames_checked = 0;
        frames_sent    = 0;
        bad_sum_sent   = 0;
        broken_headers = 0;
        mismatch_count = 0;
        error_count    = 0;
        shadow_phase   = gtfp_pkg::HUNT_SYNC0;
        shadow_pos     = '0;
        shadow_sum     = 8'h00;
        for (int i = 0; i < gtfp_pkg::PAYLOAD_LEN; i++)
            shadow_store[i] = 8'h00;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_status_codes();
        test_bad_checksum();
        test_header_in_payload();
        test_broken_header();
        test_back_to_back();
        source_gaps_on = 1'b1;
        test_drain_pause();
        test_random_traffic();

        wait_drained();
        if (frames_due.size() != 0)
        begin
            error_count += frames_due.size();
            $display("tb_top: %0d frames never delivered", frames_due.size());
        end

        $display("tb_top: %0d bytes sent, %0d whole frames (%0d with bad checksum)",
                 bytes_sent, frames_sent, bad_sum_sent);
        $display("tb_top: %0d frames checked, %0d broken headers, %0d mismatches",
                 frames_checked, broken_headers, mismatch_count);
        if (mismatch_count == 0 && error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
